### rtl/sud_pkg.sv
// Shared types and operation codes for the pipelined restoring divider.
package sud_pkg;

  // Operation codes carried on the op port.
  typedef enum logic [1:0] {
    OP_UDIV = 2'd0,
    OP_UREM = 2'd1,
    OP_SDIV = 2'd2,
    OP_SREM = 2'd3
  } op_code_t;

  // Control that travels down the pipeline beside each transaction.
  typedef struct packed {
    logic valid;
    logic sel_rem;
    logic neg_res;
  } sud_ctl_t;

endpackage

### rtl/signed_unsigned_divider_64.sv
// Pipelined signed and unsigned divider built as a chain of restoring cells.
//
// A transaction is accepted at a rising clock edge where start is high and
// busy is low. It carries op (unsigned quotient, unsigned remainder, signed
// quotient, signed remainder), dividend and divisor. busy is always low: the
// pipeline takes a new transaction in every cycle.
// The input stage forms operand magnitudes, then WIDTH identical cells each
// retire one quotient bit, and an output stage applies the sign and selects
// quotient or remainder. The result appears on result with done high for
// exactly one cycle, after passing the input register, the WIDTH cell
// registers and the output register. Throughput is one transaction per cycle;
// the chain holds one cell per quotient bit.
// Division by zero gives all ones for an unsigned quotient and the dividend
// for a remainder; the signed quotient by zero is 1 for a negative dividend.
// Reset clears every valid flag in the chain, so transactions in flight are
// dropped and done stays low until new work arrives. The receiver cannot
// stall: each result must be taken in the cycle it is shown.
module signed_unsigned_divider_64 import sud_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       op,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             done,
  output logic [WIDTH-1:0] result
);

  sud_ctl_t         ctl_s [WIDTH+1];
  logic [WIDTH-1:0] rem_s [WIDTH+1];
  logic [WIDTH-1:0] shq_s [WIDTH+1];
  logic [WIDTH-1:0] dsr_s [WIDTH+1];
  logic [WIDTH-1:0] value;
  logic [WIDTH-1:0] result_next;

  // The pipeline never refuses a transaction.
  assign busy = 1'b0;

  // Input stage.
  sud_prep #(.WIDTH(WIDTH)) u_prep (
    .clk      (clk),
    .rst      (rst),
    .accept   (start & ~busy),
    .op       (op),
    .dividend (dividend),
    .divisor  (divisor),
    .ctl_out  (ctl_s[0]),
    .rem_out  (rem_s[0]),
    .shq_out  (shq_s[0]),
    .dsr_out  (dsr_s[0])
  );

  // Chain of division cells, one per quotient bit.
  for (genvar i = 0; i < WIDTH; i++) begin : g_cell
    sud_cell #(.WIDTH(WIDTH)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl_in  (ctl_s[i]),
      .rem_in  (rem_s[i]),
      .shq_in  (shq_s[i]),
      .dsr_in  (dsr_s[i]),
      .ctl_out (ctl_s[i+1]),
      .rem_out (rem_s[i+1]),
      .shq_out (shq_s[i+1]),
      .dsr_out (dsr_s[i+1])
    );
  end

  // Output stage: pick quotient or remainder and apply the sign.
  always_comb begin
    value       = ctl_s[WIDTH].sel_rem ? rem_s[WIDTH] : shq_s[WIDTH];
    result_next = ctl_s[WIDTH].neg_res ? (-value) : value;
  end

  // The strobe is cleared at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_s[WIDTH].valid;
    end
  end

  // Result register loads every cycle.
  always_ff @(posedge clk) begin
    result <= result_next;
  end

  // Every accepted transaction produces its strobe.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(WIDTH+2) done)
    else $error("accepted transaction produced no result");

  // No strobe appears without an accepted transaction.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, WIDTH+2))
    else $error("result strobe without an accepted transaction");

  // Unsigned division by zero yields all ones.
  a_udiv_zero: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == OP_UDIV && divisor == '0)
      |-> ##(WIDTH+2) (result == {WIDTH{1'b1}}))
    else $error("unsigned division by zero did not give all ones");

endmodule

### rtl/sud_prep.sv
// Input stage: takes operand magnitudes and decodes the operation.
module sud_prep import sud_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [1:0]       op,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output sud_ctl_t         ctl_out,
  output logic [WIDTH-1:0] rem_out,
  output logic [WIDTH-1:0] shq_out,
  output logic [WIDTH-1:0] dsr_out
);

  op_code_t         opc;
  logic             is_signed;
  logic             nneg;
  logic             dneg;
  sud_ctl_t         ctl_next;
  logic [WIDTH-1:0] mag_n;
  logic [WIDTH-1:0] mag_d;

  // Decode the operation and take magnitudes of signed operands.
  always_comb begin
    opc              = op_code_t'(op);
    is_signed        = (opc == OP_SDIV) || (opc == OP_SREM);
    nneg             = is_signed & dividend[WIDTH-1];
    dneg             = is_signed & divisor[WIDTH-1];
    mag_n            = nneg ? (-dividend) : dividend;
    mag_d            = dneg ? (-divisor) : divisor;
    ctl_next.valid   = accept;
    ctl_next.sel_rem = (opc == OP_UREM) || (opc == OP_SREM);
    ctl_next.neg_res = ctl_next.sel_rem ? nneg : (nneg ^ dneg);
  end

  // Valid flag is cleared at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_next.valid;
    end
  end

  // Payload registers load every cycle.
  always_ff @(posedge clk) begin
    ctl_out.sel_rem <= ctl_next.sel_rem;
    ctl_out.neg_res <= ctl_next.neg_res;
    rem_out         <= '0;
    shq_out         <= mag_n;
    dsr_out         <= mag_d;
  end

endmodule

### rtl/sud_cell.sv
// One restoring division step: shift, trial subtract, keep or restore.
module sud_cell import sud_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  sud_ctl_t         ctl_in,
  input  logic [WIDTH-1:0] rem_in,
  input  logic [WIDTH-1:0] shq_in,
  input  logic [WIDTH-1:0] dsr_in,
  output sud_ctl_t         ctl_out,
  output logic [WIDTH-1:0] rem_out,
  output logic [WIDTH-1:0] shq_out,
  output logic [WIDTH-1:0] dsr_out
);

  logic [WIDTH+1:0] diff;
  logic             borrow;
  logic [WIDTH-1:0] rem_next;
  logic [WIDTH-1:0] shq_next;

  // The partial remainder gets the next dividend bit; the divisor is
  // subtracted when it fits. Quotient bits shift in as dividend bits leave.
  always_comb begin
    diff     = {1'b0, rem_in, shq_in[WIDTH-1]} - {2'b00, dsr_in};
    borrow   = diff[WIDTH+1];
    rem_next = borrow ? {rem_in[WIDTH-2:0], shq_in[WIDTH-1]} : diff[WIDTH-1:0];
    shq_next = {shq_in[WIDTH-2:0], ~borrow};
  end

  // Valid flag is cleared at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
  end

  // Payload registers load every cycle.
  always_ff @(posedge clk) begin
    ctl_out.sel_rem <= ctl_in.sel_rem;
    ctl_out.neg_res <= ctl_in.neg_res;
    rem_out         <= rem_next;
    shq_out         <= shq_next;
    dsr_out         <= dsr_in;
  end

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the pipelined signed and unsigned divider.
module tb;
  import sud_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = 64;
  localparam int HALF_PERIOD = 10;
  localparam int RESET_CYCLES = 12;
  localparam int NUM_DIRECTED = 22;
  localparam int NUM_RANDOM = 1880;
  localparam int DRAIN_CYCLES = 80;
  localparam int IDLE_LIMIT = 1500;

  localparam logic [W-1:0] ALL_ONES = {W{1'b1}};
  localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] ONE = {{(W-1){1'b0}}, 1'b1};
  localparam logic [W-1:0] ZERO = '0;

  // One row of the directed table; known marks a hand-typed answer.
  typedef struct packed {
    op_code_t     op;
    logic [W-1:0] dividend;
    logic [W-1:0] divisor;
    logic         known;
    logic [W-1:0] answer;
  } div_row_t;

  // One transaction waiting for its result.
  typedef struct packed {
    op_code_t     op;
    logic [W-1:0] dividend;
    logic [W-1:0] divisor;
    logic [W-1:0] answer;
  } div_pending_t;

  logic         clk;
  logic         rst;
  logic         start;
  logic         busy;
  logic [1:0]   op;
  logic [W-1:0] dividend;
  logic [W-1:0] divisor;
  logic         done;
  logic [W-1:0] result;

  // Answer that goes with the transaction now on the inputs.
  logic         cur_known;
  logic [W-1:0] cur_answer;

  div_pending_t pending_answers[$];
  div_row_t     directed_rows[NUM_DIRECTED];
  int           accepted_count = 0;
  int           error_count = 0;
  int           idle_cycles = 0;
  bit           no_gaps;

  signed_unsigned_divider_64 #(.WIDTH(W)) dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .op       (op),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (done),
    .result   (result)
  );

  // Free-running clock.
  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // Restoring long division on magnitudes, followed by sign fix-up.
  function automatic logic [W-1:0] divide_predict(op_code_t code, logic [W-1:0] num_in,
                                                  logic [W-1:0] den_in);
    logic [W-1:0] num;
    logic [W-1:0] den;
    logic [W-1:0] quo;
    logic [W:0]   rem;
    logic         num_neg;
    logic         den_neg;
    logic         is_signed;
    begin
      is_signed = (code == OP_SDIV) || (code == OP_SREM);
      num_neg = is_signed && num_in[W-1];
      den_neg = is_signed && den_in[W-1];
      num = num_neg ? -num_in : num_in;
      den = den_neg ? -den_in : den_in;
      quo = '0;
      rem = '0;
      if (den == ZERO) begin
        quo = ALL_ONES;
        rem = {1'b0, num};
      end else begin
        for (int i = W - 1; i >= 0; i--) begin
          rem = {rem[W-1:0], num[i]};
          if (rem >= {1'b0, den}) begin
            rem = rem - {1'b0, den};
            quo[i] = 1'b1;
          end
        end
      end
      case (code)
        OP_UDIV: divide_predict = quo;
        OP_UREM: divide_predict = rem[W-1:0];
        OP_SDIV: divide_predict = (num_neg != den_neg) ? -quo : quo;
        default: divide_predict = num_neg ? -rem[W-1:0] : rem[W-1:0];
      endcase
    end
  endfunction

  // Operand drawn from a mix of shapes that stress the long division.
  function automatic logic [W-1:0] random_operand();
    logic [W-1:0] val;
    begin
      val = {$urandom, $urandom};
      case ($urandom_range(0, 9))
        0: val = W'($urandom_range(0, 255));
        1: val = -W'($urandom_range(1, 255));
        2: val = ZERO;
        3: begin
          case ($urandom_range(0, 4))
            0: val = ALL_ONES;
            1: val = MOST_NEG;
            2: val = MOST_POS;
            3: val = ONE;
            default: val = MOST_NEG + ONE;
          endcase
        end
        4: val = ONE << $urandom_range(0, W - 1);
        5: val = val >> $urandom_range(0, W - 1);
        6: val = ~(val >> $urandom_range(0, W - 1));
        default: ;
      endcase
      random_operand = val;
    end
  endfunction

  // Presents one transaction, after an optional gap, and holds it until taken.
  task automatic send_item(input op_code_t code, input logic [W-1:0] num,
                           input logic [W-1:0] den, input logic known,
                           input logic [W-1:0] answer);
    int gap;
    int seen;
    begin
      gap = no_gaps ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        start = 1'b0;
        repeat (gap) @(negedge clk);
      end
      op = code;
      dividend = num;
      divisor = den;
      cur_known = known;
      cur_answer = answer;
      start = 1'b1;
      seen = accepted_count;
      do @(negedge clk); while (accepted_count == seen);
    end
  endtask

  // Record accepted transactions and check each result against the oldest one.
  always @(posedge clk) begin
    div_pending_t head;
    if (!rst) begin
      if (start && !busy) begin
        head.op = op_code_t'(op);
        head.dividend = dividend;
        head.divisor = divisor;
        head.answer = cur_known ? cur_answer : divide_predict(op_code_t'(op), dividend, divisor);
        pending_answers.push_back(head);
        accepted_count++;
      end
      if (done) begin
        if (pending_answers.size() == 0) begin
          $display("%0t: unexpected result %h with nothing outstanding", $time, result);
          error_count++;
        end else begin
          head = pending_answers.pop_front();
          if (result !== head.answer) begin
            $display("%0t: %s %h / %h: expected %h, actual %h", $time, head.op.name(),
                     head.dividend, head.divisor, head.answer, result);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog on cycles in which no transaction and no result moves.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: timeout with %0d results outstanding", $time, pending_answers.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Directed table followed by random traffic, then drain and verdict.
  initial begin
    logic [W-1:0] num;
    logic [W-1:0] den;
    op_code_t     code;

    rst = 1'b1;
    start = 1'b0;
    op = OP_UDIV;
    dividend = '0;
    divisor = '0;
    cur_known = 1'b0;
    cur_answer = '0;
    no_gaps = 1'b0;

    // Plain cases use the predictor; most corner cases carry typed answers.
    directed_rows = '{
      '{OP_UDIV, 64'd100, 64'd7, 1'b0, ZERO},
      '{OP_UREM, 64'd100, 64'd7, 1'b0, ZERO},
      '{OP_SDIV, -64'd100, 64'd7, 1'b0, ZERO},
      '{OP_SREM, -64'd100, 64'd7, 1'b0, ZERO},
      '{OP_SDIV, 64'd100, -64'd7, 1'b0, ZERO},
      '{OP_SREM, 64'd100, -64'd7, 1'b0, ZERO},
      '{OP_SDIV, -64'd100, -64'd7, 1'b0, ZERO},
      '{OP_UDIV, 64'h1234_5678_9abc_def0, ZERO, 1'b1, ALL_ONES},
      '{OP_UREM, 64'h1234_5678_9abc_def0, ZERO, 1'b1, 64'h1234_5678_9abc_def0},
      '{OP_SDIV, -64'd5, ZERO, 1'b1, ONE},
      '{OP_SDIV, 64'd5, ZERO, 1'b1, ALL_ONES},
      '{OP_SREM, -64'd5, ZERO, 1'b1, -64'd5},
      '{OP_UDIV, ALL_ONES, ONE, 1'b1, ALL_ONES},
      '{OP_UDIV, ALL_ONES, ALL_ONES, 1'b1, ONE},
      '{OP_UREM, ALL_ONES, ALL_ONES, 1'b1, ZERO},
      '{OP_UDIV, ZERO, ALL_ONES, 1'b1, ZERO},
      '{OP_UREM, 64'd5, ALL_ONES, 1'b1, 64'd5},
      '{OP_SDIV, MOST_NEG, ALL_ONES, 1'b1, MOST_NEG},
      '{OP_SREM, MOST_NEG, ALL_ONES, 1'b1, ZERO},
      '{OP_SDIV, MOST_NEG, ONE, 1'b1, MOST_NEG},
      '{OP_SDIV, MOST_NEG, MOST_NEG, 1'b1, ONE},
      '{OP_UDIV, ALL_ONES, MOST_NEG, 1'b0, ZERO}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].op, directed_rows[i].dividend, directed_rows[i].divisor,
                directed_rows[i].known, directed_rows[i].answer);
    end

    // Random traffic in blocks, some of them back to back with no gaps.
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i % 64 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      code = op_code_t'($urandom_range(0, 3));
      num = random_operand();
      case ($urandom_range(0, 7))
        0: den = num;
        1: den = num + ONE;
        2: den = num - ONE;
        3: den = -num;
        default: den = random_operand();
      endcase
      send_item(code, num, den, 1'b0, ZERO);
    end
    start = 1'b0;

    // Wait for the pipeline to empty, then watch for stray results.
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### sim.f
rtl/sud_pkg.sv
rtl/sud_prep.sv
rtl/sud_cell.sv
rtl/signed_unsigned_divider_64.sv
tb/sv/tb.sv
